@@ hw/rtl/erts_pkg.sv @@
`default_nettype none

package erts_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_SKIP = 2'd0,
    REG_TERMINATOR  = 2'd1,
    REG_STRING_TYPE = 2'd2
  } cfg_reg_e;

  localparam logic [7:0]  HeaderSkipRst = 8'd8;
  localparam logic [15:0] TerminatorRst = 16'hb33f;
  localparam logic [15:0] StringTypeRst = 16'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE_LO = 3'd1,
    PH_TYPE_HI = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]  header_skip_bytes;
    logic [15:0] terminator_type;
    logic [15:0] string_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       truncated;
  } out_item_t;

  // one parsed byte, as handed from the parser to the output buffer
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } parse_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/event_record_tlv_string_extractor_unit.sv @@
// Pulls string payloads out of a stream of type-length-value event records.
// Input channel: one buffer byte per transaction (in_valid_i / stall_o), with
// buffer_end set on the final byte of a buffer. Each record skips
// header_skip_bytes bytes, then walks 16-bit little-endian type and length
// fields; payload bytes of string-type arguments leave on the output channel
// (out_valid_o / stall_i) with string_end on the last one. A byte waits in
// the input register, then goes through the parser into the output register
// or its skid. Throughput is one byte per cycle while the skid is empty;
// bytes that produce no result are simply consumed. The output register has a
// one-entry skid stage behind it, so a stall on stall_i only pushes back on
// the input once the skid is full. Reset clears the parser to the header
// phase and loads the registers with skip 8, terminator 0xb33f, string type
// 2. Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the block is idle, a rule on the user that the block does not enforce.
// A buffer that ends inside a record yields a result with truncated set.
`default_nettype none

module event_record_tlv_string_extractor_unit import erts_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  in_item_t            in_data_i,
  output logic                stall_o,
  output logic                out_valid_o,
  output out_item_t           out_data_o,
  input  wire                 stall_i,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  in_item_t   in_q;
  logic       advance;
  logic       step;
  logic       in_accept;
  parse_res_t res;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       skid_valid_q, skid_valid_d;
  out_item_t  skid_q, skid_d;
  logic       pop;
  logic       push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_skip_bytes <= HeaderSkipRst;
      cfg_q.terminator_type   <= TerminatorRst;
      cfg_q.string_type       <= StringTypeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HEADER_SKIP: cfg_q.header_skip_bytes <= cfg_wdata_i[7:0];
        REG_TERMINATOR:  cfg_q.terminator_type   <= cfg_wdata_i;
        REG_STRING_TYPE: cfg_q.string_type       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // parser steps only when the skid has room for a possible result
  assign advance   = !skid_valid_q;
  assign step      = in_valid_q && advance;
  assign stall_o   = in_valid_q && !advance;
  assign in_accept = in_valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  erts_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign push = step && res.emit;
  assign pop  = out_valid_q && !stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = push;
        skid_d       = res.item;
      end else begin
        out_valid_d = push;
        out_d       = res.item;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a transaction while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !skid_valid_q)
    else $error("result produced with no room in the output buffer");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  a_marker_meaning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !res.item.has_byte) |->
      ((res.item.string_end || res.item.truncated) && res.item.out_byte == 8'd0))
    else $error("marker result carries neither end nor truncation");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/erts_parser.sv @@
`default_nettype none

module erts_parser import erts_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        step_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output parse_res_t res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  type_lo_q, type_lo_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic        str_q, str_d;
  logic [15:0] type_word;
  logic [15:0] len_word;
  logic [15:0] cnt_dec;

  assign type_word = {item_i.in_byte, type_lo_q};
  assign len_word  = {item_i.in_byte, len_lo_q};

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    type_lo_d = type_lo_q;
    len_lo_d  = len_lo_q;
    str_d     = str_q;
    cnt_dec   = cnt_q - 16'd1;
    res_o     = '0;

    // header done once the skip count reaches the live register value
    if (phase_d == PH_HEADER && cnt_d >= {8'd0, cfg_i.header_skip_bytes}) begin
      phase_d = PH_TYPE_LO;
      cnt_d   = '0;
    end

    unique case (phase_d)
      PH_TYPE_LO: begin
        type_lo_d = item_i.in_byte;
        phase_d   = PH_TYPE_HI;
      end
      PH_TYPE_HI: begin
        if (type_word == cfg_i.terminator_type) begin
          phase_d = PH_HEADER;
          cnt_d   = '0;
          str_d   = 1'b0;
        end else begin
          str_d   = (type_word == cfg_i.string_type);
          phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_lo_d = item_i.in_byte;
        phase_d  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len_word == 16'd0) begin
          // empty string gives a lone end marker
          if (str_q) begin
            res_o.emit            = 1'b1;
            res_o.item.string_end = 1'b1;
          end
          str_d   = 1'b0;
          phase_d = PH_TYPE_LO;
        end else begin
          cnt_d   = len_word;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        cnt_d = cnt_dec;
        if (str_q) begin
          res_o.emit            = 1'b1;
          res_o.item.out_byte   = item_i.in_byte;
          res_o.item.has_byte   = 1'b1;
          res_o.item.string_end = (cnt_dec == 16'd0);
        end
        if (cnt_dec == 16'd0) begin
          str_d   = 1'b0;
          phase_d = PH_TYPE_LO;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        cnt_d   = cnt_d + 16'd1;
      end
    endcase

    if (item_i.buffer_end) begin
      if (!(phase_d == PH_HEADER && cnt_d == 16'd0)) begin
        res_o.emit           = 1'b1;
        res_o.item.truncated = 1'b1;
      end
      phase_d   = PH_HEADER;
      cnt_d     = '0;
      type_lo_d = '0;
      len_lo_d  = '0;
      str_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      cnt_q     <= '0;
      type_lo_q <= '0;
      len_lo_q  <= '0;
      str_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      type_lo_q <= type_lo_d;
      len_lo_q  <= len_lo_d;
      str_q     <= str_d;
    end
  end

endmodule

`default_nettype wire
